// ===== rtl/idsa_pkg.sv =====
// ----------------------------------------------------------------------------
// idsa_pkg: shared types and constants
// action and status codes, cell control bundle and sizing constants
// ----------------------------------------------------------------------------
package idsa_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // width used for positions, counts and index compares
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CMP_W-1:0]  pos_t;

  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_PUSH   = 3'd2,
    ACT_POP    = 3'd3,
    ACT_INSERT = 3'd4,
    ACT_REMOVE = 3'd5,
    ACT_FIND   = 3'd6,
    ACT_CLEAR  = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic  en;     // state update enabled this cycle
    act_t  act;
    pos_t  idx;
    pos_t  cnt;
    pos_t  last;   // cnt - 1
    pos_t  raddr;  // position to read out
    word_t value;
  } ctrl_t;

endpackage

// ===== rtl/idsa_cell.sv =====
// ----------------------------------------------------------------------------
// idsa_cell: one storage slot of the shift array
// holds one word, loads, shifts from a neighbor or clears under broadcast control
// ----------------------------------------------------------------------------
module idsa_cell
  import idsa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  pos_t  pos,
  input  ctrl_t ctrl,
  input  word_t left_i,
  input  word_t right_i,
  output word_t data_o,
  output logic  match_o,
  output word_t rd_o
);

  word_t data_r;
  word_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.en) begin
      case (ctrl.act)
        ACT_WRITE: begin
          if (pos == ctrl.idx) data_nxt = ctrl.value;
        end
        ACT_PUSH: begin
          if (pos == ctrl.cnt) data_nxt = ctrl.value;
        end
        ACT_POP: begin
          if (pos == ctrl.last) data_nxt = '0;
        end
        ACT_INSERT: begin
          if (pos == ctrl.idx) begin
            data_nxt = ctrl.value;
          end else if (pos > ctrl.idx && pos <= ctrl.cnt) begin
            data_nxt = left_i;
          end
        end
        ACT_REMOVE: begin
          if (pos == ctrl.last) begin
            data_nxt = '0;
          end else if (pos >= ctrl.idx && pos < ctrl.last) begin
            data_nxt = right_i;
          end
        end
        ACT_CLEAR: data_nxt = '0;
        default:   data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_o  = data_r;
  assign match_o = (pos < ctrl.cnt) && (data_r == ctrl.value);
  assign rd_o    = (pos == ctrl.raddr) ? data_r : '0;

endmodule

// ===== rtl/insert_delete_shift_array_unit.sv =====
// ----------------------------------------------------------------------------
// insert_delete_shift_array_unit: ordered word array with insert and delete
// a row of cells that shift, load and compare in parallel; while unstalled, one request a cycle
// ----------------------------------------------------------------------------
//
//  channel  dir  width  contents
//  in_*     in   40     action, index, value request
//  out_*    out  48     read_value, found, found_index, count, status
//
//  each request finishes in the cycle it is accepted: one request per cycle while
//  the output does not stall, as the cell row shifts and compares every slot at once
//  the result lands in an output register; a new request is taken whenever
//  that register is empty or is being drained in the same cycle
//  reset clears every cell, the element count and the output valid
//  an output stall holds the result and stops input acceptance
//
module insert_delete_shift_array_unit
  import idsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // action[2:0], index[6:3], value[38:7], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], found[32], found_index[36:33],
                                  // count[41:37], status[43:42], zero pad
);

  // request fields
  act_t       act;
  logic [3:0] in_index;
  word_t      in_value;
  pos_t       idx_w;
  pos_t       cnt_w;

  // element count
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // result register
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic [47:0] out_data_nxt;

  logic    accept;
  logic    ok;
  status_t status;
  ctrl_t   ctrl;

  word_t cell_data [DEPTH];
  word_t cell_rd   [DEPTH];
  logic  match     [DEPTH];

  word_t rd_any;
  word_t read_value;
  logic  found;
  pos_t  fidx;

  assign act      = act_t'(in_tdata[2:0]);
  assign in_index = in_tdata[6:3];
  assign in_value = in_tdata[38:7];
  assign idx_w    = CMP_W'(in_index);
  assign cnt_w    = CMP_W'(count_r);

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // status and next count per action
  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    case (act)
      ACT_READ: begin
        if (idx_w >= cnt_w) status = ST_RANGE;
      end
      ACT_WRITE: begin
        if (idx_w < CMP_W'(DEPTH)) begin
          if (idx_w >= cnt_w) count_nxt = CNT_W'(idx_w + 1'b1);
        end else begin
          status = ST_RANGE;
        end
      end
      ACT_PUSH: begin
        if (cnt_w >= CMP_W'(DEPTH)) status = ST_FULL;
        else count_nxt = count_r + 1'b1;
      end
      ACT_POP: begin
        if (count_r == '0) status = ST_EMPTY;
        else count_nxt = count_r - 1'b1;
      end
      ACT_INSERT: begin
        if (idx_w > cnt_w) status = ST_RANGE;
        else if (cnt_w >= CMP_W'(DEPTH)) status = ST_FULL;
        else count_nxt = count_r + 1'b1;
      end
      ACT_REMOVE: begin
        if (count_r == '0) status = ST_EMPTY;
        else if (idx_w >= cnt_w) status = ST_RANGE;
        else count_nxt = count_r - 1'b1;
      end
      ACT_FIND:  status = ST_OK;
      ACT_CLEAR: count_nxt = '0;
      default:   status = ST_OK;
    endcase
  end

  assign ok = (status == ST_OK);

  // control broadcast to the cell row
  always_comb begin
    ctrl.en    = accept && ok;
    ctrl.act   = act;
    ctrl.idx   = idx_w;
    ctrl.cnt   = cnt_w;
    ctrl.last  = cnt_w - 1'b1;
    // pop reads the last element, everything else reads at index
    ctrl.raddr = (act == ACT_POP) ? (cnt_w - 1'b1) : idx_w;
    ctrl.value = in_value;
  end

  // row of cells, each sees both neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    idsa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .pos     (CMP_W'(g)),
      .ctrl    (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .match_o (match[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // gather the selected word and the first match
  always_comb begin
    rd_any = '0;
    found  = 1'b0;
    fidx   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        fidx  = CMP_W'(i);
      end
    end
  end

  always_comb begin
    read_value = '0;
    if (ok && (act == ACT_READ || act == ACT_POP)) read_value = rd_any;
    out_data_nxt        = '0;
    out_data_nxt[31:0]  = read_value;
    out_data_nxt[32]    = (act == ACT_FIND) && found;
    out_data_nxt[36:33] = (act == ACT_FIND && found) ? fidx[3:0] : 4'd0;
    out_data_nxt[41:37] = 5'(CMP_W'(count_nxt));
    out_data_nxt[43:42] = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== bench/shift_array_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_array_checker: result checker for the insert/delete shift array
// mirrors the array contents and element count for each accepted request and
// compares every accepted result with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module shift_array_checker
  import idsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          fail_count,
  output int          outstanding,
  output int          n_checked,
  output int          n_flagged,
  output int          n_matched
);

  typedef struct packed {
    word_t      read_value;
    logic       found;
    logic [3:0] found_index;
    logic [4:0] count;
    status_t    status;
  } reply_t;

  word_t  slots [DEPTH];
  int     fill;
  reply_t reply_q [$];

  initial begin
    fail_count = 0;
    outstanding = 0;
    n_checked = 0;
    n_flagged = 0;
    n_matched = 0;
  end

  // one array action on the mirrored state
  function automatic reply_t array_step(act_t act, logic [3:0] idx, word_t val);
    reply_t r;
    int     i;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_READ: begin
        if (int'(idx) < fill) r.read_value = slots[idx];
        else r.status = ST_RANGE;
      end
      ACT_WRITE: begin
        if (int'(idx) < DEPTH) begin
          slots[idx] = val;
          if (int'(idx) >= fill) fill = int'(idx) + 1;
        end else begin
          r.status = ST_RANGE;
        end
      end
      ACT_PUSH: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[fill] = val;
          fill++;
        end
      end
      ACT_POP: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          fill--;
          r.read_value = slots[fill];
          slots[fill] = '0;
        end
      end
      ACT_INSERT: begin
        // range test comes before the full test
        if (int'(idx) > fill) begin
          r.status = ST_RANGE;
        end else if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = fill; i > int'(idx); i--) slots[i] = slots[i-1];
          slots[idx] = val;
          fill++;
        end
      end
      ACT_REMOVE: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(idx) >= fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(idx); i + 1 < fill; i++) slots[i] = slots[i+1];
          fill--;
          slots[fill] = '0;
        end
      end
      ACT_FIND: begin
        // first match among held elements only
        for (i = 0; i < fill; i++) begin
          if (!r.found && slots[i] == val) begin
            r.found = 1'b1;
            r.found_index = i[3:0];
          end
        end
      end
      default: begin
        for (i = 0; i < DEPTH; i++) slots[i] = '0;
        fill = 0;
      end
    endcase
    r.count = fill[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: result %0d, %s: expected %h, got %h", $time, n_checked, what,
             want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    reply_t got;
    int     i;
    if (!rst_n) begin
      for (i = 0; i < DEPTH; i++) slots[i] = '0;
      fill = 0;
      reply_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_value  = out_tdata[31:0];
        got.found       = out_tdata[32];
        got.found_index = out_tdata[36:33];
        got.count       = out_tdata[41:37];
        got.status      = status_t'(out_tdata[43:42]);
        if (reply_q.size() == 0) begin
          report_mismatch("result with no request waiting", '0, out_tdata[31:0]);
        end else begin
          want = reply_q.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, got.read_value);
          if (got.found !== want.found)
            report_mismatch("found", 32'(want.found), 32'(got.found));
          if (got.found_index !== want.found_index)
            report_mismatch("found_index", 32'(want.found_index), 32'(got.found_index));
          if (got.count !== want.count)
            report_mismatch("count", 32'(want.count), 32'(got.count));
          if (got.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(got.status));
          if (out_tdata[47:44] !== 4'd0)
            report_mismatch("pad bits", '0, 32'(out_tdata[47:44]));
          if (want.status != ST_OK) n_flagged++;
          if (want.found) n_matched++;
        end
        n_checked++;
      end
      if (in_tvalid && in_tready)
        reply_q.push_back(array_step(act_t'(in_tdata[2:0]), in_tdata[6:3],
                                     in_tdata[38:7]));
    end
    outstanding <= reply_q.size();
  end

endmodule

// ===== bench/tb_insert_delete_shift_array_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_insert_delete_shift_array_unit: testbench for the shift array unit
// directed corner requests, then fill/drain phases of random requests with
// random idling on both channels; a separate checker predicts every result
// ----------------------------------------------------------------------------
module tb_insert_delete_shift_array_unit
  import idsa_pkg::*;
();

  localparam int N_RANDOM   = 730;
  localparam int IDLE_LIMIT = 2000;   // cycles with no handshake before giving up
  localparam int TAIL       = 8;      // settle time after the last result

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // action[2:0], index[6:3], value[38:7], zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // read_value[31:0], found[32], found_index[36:33],
                            // count[41:37], status[43:42], zero pad

  int fail_count;
  int outstanding;
  int n_checked;
  int n_flagged;
  int n_matched;
  int n_sent;
  int n_directed;
  int idle_cycles;
  bit calm;                 // when set, neither side idles
  word_t value_pool [8];    // recurring words so that finds hit

  insert_delete_shift_array_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  shift_array_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .n_checked   (n_checked),
    .n_flagged   (n_flagged),
    .n_matched   (n_matched)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // result side: random stall before each result, none while calm
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // watchdog: any handshake resets the idle count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with tvalid still high so back-to-back requests stay valid
  task automatic issue_request(act_t act, logic [3:0] idx, word_t val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, val, idx, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    n_sent++;
  endtask

  // hold the request channel until every predicted result has drained
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // action mix: filling phases grow the array, draining phases shrink it
  function automatic act_t pick_action(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ACT_CLEAR;
    if (r < 15) return ACT_READ;
    if (r < 27) return ACT_FIND;
    if (r < 37) return ACT_WRITE;
    if (filling) begin
      if (r < 62) return ACT_PUSH;
      if (r < 87) return ACT_INSERT;
      if (r < 93) return ACT_POP;
      return ACT_REMOVE;
    end
    if (r < 62) return ACT_POP;
    if (r < 87) return ACT_REMOVE;
    if (r < 93) return ACT_PUSH;
    return ACT_INSERT;
  endfunction

  initial begin : stimulus
    int   k;
    bit   filling;
    act_t act;
    logic [3:0] idx;
    word_t val;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    calm = 1'b0;
    n_sent = 0;
    idle_cycles = 0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hffff_ffff;
    value_pool[2] = 32'h7fff_ffff;
    value_pool[3] = 32'h8000_0000;
    for (k = 4; k < 8; k++) value_pool[k] = $urandom;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty array corners
    issue_request(ACT_POP,    4'd0,  32'h1234_5678);
    issue_request(ACT_REMOVE, 4'd0,  32'h0);
    issue_request(ACT_READ,   4'd0,  32'h0);
    issue_request(ACT_INSERT, 4'd1,  32'h0);
    issue_request(ACT_FIND,   4'd0,  32'h0);
    // write past the end fills the array, skipped slots read as zero
    issue_request(ACT_WRITE,  4'd15, 32'h7fff_ffff);
    issue_request(ACT_READ,   4'd3,  32'h0);
    issue_request(ACT_READ,   4'd15, 32'h0);
    // full array
    issue_request(ACT_PUSH,   4'd0,  32'h1);
    issue_request(ACT_INSERT, 4'd5,  32'h1);
    issue_request(ACT_FIND,   4'd0,  32'h7fff_ffff);
    issue_request(ACT_FIND,   4'd0,  32'h0);
    issue_request(ACT_POP,    4'd0,  32'h0);
    issue_request(ACT_REMOVE, 4'd15, 32'h0);
    issue_request(ACT_REMOVE, 4'd0,  32'h0);
    issue_request(ACT_CLEAR,  4'd0,  32'h0);
    // front insert, append at the end, insert out of range
    issue_request(ACT_PUSH,   4'd0,  32'h8000_0000);
    issue_request(ACT_INSERT, 4'd0,  32'hffff_ffff);
    issue_request(ACT_INSERT, 4'd2,  32'h5a5a_5a5a);
    issue_request(ACT_INSERT, 4'd4,  32'h0);
    issue_request(ACT_READ,   4'd2,  32'h0);
    issue_request(ACT_WRITE,  4'd1,  32'ha5a5_a5a5);
    issue_request(ACT_FIND,   4'd0,  32'ha5a5_a5a5);
    issue_request(ACT_REMOVE, 4'd0,  32'h0);
    issue_request(ACT_FIND,   4'd0,  32'h8000_0000);
    n_directed = n_sent;
    drain_results();

    // random phases; each phase picks fill or drain and whether to idle
    filling = 1'b1;
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 40 == 0) begin
        filling = $urandom_range(0, 2) != 0 ? ~filling : filling;
        calm = $urandom_range(0, 3) == 0;
      end
      if (k % 150 == 75) drain_results();
      act = pick_action(filling);
      idx = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
      val = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : word_t'($urandom);
      issue_request(act, idx, val);
    end

    // wind down: wait for every result, then let the pipeline settle
    calm = 1'b0;
    drain_results();
    repeat (TAIL) @(posedge clk);

    $display("covered %0d requests (%0d directed corners, the rest random fill/drain",
             n_sent, n_directed);
    $display("phases); %0d results checked, %0d flagged full/empty/range, %0d finds hit",
             n_checked, n_flagged, n_matched);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
